@@ hw/rtl/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

  // Fixed port widths
  localparam int IN_WORD_W = 32;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 3;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] status_t;

  // Request codes
  localparam req_t REQ_PUSH   = 2'd0;
  localparam req_t REQ_POP    = 2'd1;
  localparam req_t REQ_READ   = 2'd2;
  localparam req_t REQ_REMOVE = 2'd3;

  // Status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

@@ hw/rtl/deq_ram.sv @@
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/deq_slot_unit.sv @@
`timescale 1ns / 1ps

// Ring slot adder: (base + offset) mod DEPTH, both inputs below DEPTH.
module deq_slot_unit #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] slot
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= DEPTH_V) begin
      sum = sum - DEPTH_V;
    end
    slot = sum[AW-1:0];
  end

endmodule

@@ hw/rtl/double_ended_queue_core.sv @@
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH words held in a ring of one RAM
// (one write port, one registered read port). Each input item is one
// request: push at either end, pop from either end, read at a position
// counted from the head, or remove the first word equal to in_value,
// searched from the chosen end, with the entries behind it moved up to
// close the gap. Every item yields exactly one result: data, status and
// the entry count after the request. A push and any failing request
// (full, empty, out of range, remove on empty) finish in the accept
// cycle; pop and read pass through S_FETCH and S_DONE because of the
// RAM's registered read; a remove passes through S_SCAN and S_CMP for
// each entry compared and, on a match, through S_SHRD and S_SHWR for
// each entry moved, since each of these steps makes at most one RAM
// access through the single shared slot adder. The block takes a
// new item only when the sequencer is idle and the result register is
// free or being emptied. The RAM is not cleared: only held entries are
// ever read.
module double_ended_queue_core #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [deq_pkg::REQ_W-1:0]           in_req_type,
  input  logic                                in_from_tail,
  input  logic signed [deq_pkg::IN_WORD_W-1:0] in_value,
  input  logic [deq_pkg::POS_W-1:0]           in_position,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [deq_pkg::IN_WORD_W-1:0] out_read_value,
  output logic [deq_pkg::STAT_W-1:0]          out_status,
  output logic [deq_pkg::CNT_OUT_W-1:0]       out_count
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_OFF = AW'(DEPTH - 1);

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // take a request
    S_FETCH = 7'b0000010,  // pop/read data back from RAM
    S_SCAN  = 7'b0000100,  // remove: read next candidate
    S_CMP   = 7'b0001000,  // remove: compare candidate
    S_SHRD  = 7'b0010000,  // compaction: read entry k+1
    S_SHWR  = 7'b0100000,  // compaction: write it to entry k
    S_DONE  = 7'b1000000   // result waits for the output register
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   tail_r, tail_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [WORD_BITS-1:0]   data_r, data_nxt;
  status_t                stat_r, stat_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [IN_WORD_W-1:0]   out_data_r, out_data_nxt;
  status_t                out_stat_r, out_stat_nxt;
  logic [CNT_OUT_W-1:0]   out_cnt_r, out_cnt_nxt;

  // shared slot adder
  logic [AW-1:0]          off;
  logic [AW-1:0]          slot;

  // RAM ports
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;

  logic                   out_free;
  logic                   in_acc;
  logic [WORD_BITS-1:0]   in_word;
  logic [CW-1:0]          scan_idx;
  logic                   range_bad;

  deq_slot_unit #(.DEPTH(DEPTH)) u_slot (
    .base   (head_r),
    .offset (off),
    .slot   (slot)
  );

  deq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // result register free now or emptied at this edge
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // pushed / matched word cut to the store width
  assign in_word   = WORD_BITS'($unsigned(in_value));
  assign range_bad = PW'(in_position) >= PW'(cnt_r);
  // logical entry under test, counted from the chosen end
  assign scan_idx  = tail_r ? (cnt_r - CW'(1) - k_r) : k_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    tail_nxt      = tail_r;
    word_nxt      = word_r;
    k_nxt         = k_r;
    data_nxt      = data_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    off           = '0;
    ram_we        = 1'b0;
    ram_waddr     = slot;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = slot;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // default: immediate result, data zero
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_stat_nxt  = ST_OK;
          unique case (in_req_type)
            REQ_PUSH: begin
              if (cnt_r == FULL_CNT) begin
                out_stat_nxt = ST_FULL;
              end else begin
                off       = in_from_tail ? cnt_r[AW-1:0] : LAST_OFF;
                ram_we    = 1'b1;
                ram_wdata = in_word;
                if (!in_from_tail) begin
                  head_nxt = slot;
                end
                cnt_nxt = cnt_r + CW'(1);
              end
              out_cnt_nxt = CNT_OUT_W'(cnt_nxt);
            end
            REQ_POP: begin
              if (cnt_r == '0) begin
                out_stat_nxt = ST_EMPTY;
                out_cnt_nxt  = CNT_OUT_W'(cnt_r);
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                ram_re        = 1'b1;
                if (in_from_tail) begin
                  off       = AW'(cnt_r - CW'(1));
                  ram_raddr = slot;
                end else begin
                  off       = AW'(1);
                  ram_raddr = head_r;
                  head_nxt  = slot;
                end
                cnt_nxt   = cnt_r - CW'(1);
                state_nxt = S_FETCH;
              end
            end
            REQ_READ: begin
              out_cnt_nxt = CNT_OUT_W'(cnt_r);
              if (range_bad) begin
                out_stat_nxt = ST_RANGE;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                off           = AW'(in_position);
                ram_re        = 1'b1;
                state_nxt     = S_FETCH;
              end
            end
            REQ_REMOVE: begin
              out_cnt_nxt = CNT_OUT_W'(cnt_r);
              if (cnt_r == '0) begin
                out_stat_nxt = ST_NOTFOUND;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                word_nxt      = in_word;
                tail_nxt      = in_from_tail;
                k_nxt         = '0;
                state_nxt     = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_FETCH: begin
        data_nxt  = ram_rdata;
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        off       = scan_idx[AW-1:0];
        ram_re    = 1'b1;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (ram_rdata == word_r) begin
          data_nxt  = ram_rdata;
          k_nxt     = scan_idx;
          state_nxt = S_SHRD;
        end else if (k_r + CW'(1) == cnt_r) begin
          data_nxt  = '0;
          stat_nxt  = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_SCAN;
        end
      end

      S_SHRD: begin
        if (k_r + CW'(1) >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else begin
          off       = AW'(k_r + CW'(1));
          ram_re    = 1'b1;
          state_nxt = S_SHWR;
        end
      end

      S_SHWR: begin
        off       = k_r[AW-1:0];
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        k_nxt     = k_r + CW'(1);
        state_nxt = S_SHRD;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = IN_WORD_W'(data_r);
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = CNT_OUT_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    tail_r     <= tail_nxt;
    word_r     <= word_nxt;
    k_r        <= k_nxt;
    data_r     <= data_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;
  assign out_status     = out_stat_r;
  assign out_count      = out_cnt_r;

endmodule

@@ hw/rtl/deq_checker.sv @@
`timescale 1ns / 1ps

module deq_checker #(
  parameter int DEPTH = 64
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [deq_pkg::IN_WORD_W-1:0] out_read_value,
  input logic [deq_pkg::STAT_W-1:0]           out_status,
  input logic [deq_pkg::CNT_OUT_W-1:0]        out_count
);

  import deq_pkg::*;

  localparam logic [CNT_OUT_W-1:0] FULL_OUT = CNT_OUT_W'(DEPTH);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_count))
    else $error("result changed while stalled");

  // an accepted item either has its result out or keeps the input stalled
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid || in_stall)
    else $error("accepted item left no result and no stall");

  // failed requests return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_read_value == '0)
    else $error("nonzero data on failed request");

  // full only at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_count == FULL_OUT)
    else $error("full status with wrong count");

  // empty only with no entries
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_count == '0)
    else $error("empty status with entries held");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int DEPTH      = 64;
  localparam int QUIET_MAX  = 3000; // cycles with no handshake before giving up
  localparam int TAIL_WAIT  = 300;  // settle time after the last result
  localparam int CALM_FIRST = 500;  // items [CALM_FIRST, CALM_LAST) run without idling
  localparam int CALM_LAST  = 700;
  localparam int HOLD_AT    = 400;  // result count at which the receiver backs off
  localparam int HOLD_LEN   = 200;

  typedef struct {
    req_t               kind;
    logic               tail;
    logic signed [31:0] value;
    logic [5:0]         pos;
    bit                 drain_first; // wait for all results before offering
  } request_t;

  typedef struct {
    logic signed [31:0] data;
    status_t            status;
    logic [6:0]         count;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type  = '0;
  logic                in_from_tail = 1'b0;
  logic signed [31:0]  in_value     = '0;
  logic [POS_W-1:0]    in_position  = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic signed [31:0]  out_read_value;
  logic [STAT_W-1:0]   out_status;
  logic [CNT_OUT_W-1:0] out_count;

  double_ended_queue_core #(.DEPTH(DEPTH), .WORD_BITS(32)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_from_tail   (in_from_tail),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow deque: ring of words, head slot, entry count.
  logic signed [31:0] deq_slots [DEPTH];
  logic [5:0]         deq_head  = '0;
  logic [6:0]         deq_count = '0;

  request_t stim_q[$];          // items not yet accepted
  result_t  pending_results[$]; // predicted results, oldest first
  logic signed [31:0] value_pool[8];

  int items_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int kind_hits[4]   = '{default: 0};
  int status_hits[5] = '{default: 0};

  function automatic logic [5:0] slot_at(int k);
    logic [5:0] s;
    s = deq_head + k[5:0];
    return s;
  endfunction

  // Applies one request to the shadow deque and returns what the block owes.
  function automatic result_t deque_apply(request_t r);
    result_t res;
    int      k;
    int      idx;
    int      hit_at;
    res.data   = '0;
    res.status = ST_OK;
    hit_at     = -1;
    case (r.kind)
      REQ_PUSH: begin
        if (deq_count == DEPTH) begin
          res.status = ST_FULL;
        end else if (r.tail) begin
          deq_slots[slot_at(deq_count)] = r.value;
          deq_count++;
        end else begin
          deq_head = deq_head - 6'd1;
          deq_slots[deq_head] = r.value;
          deq_count++;
        end
      end
      REQ_POP: begin
        if (deq_count == 0) begin
          res.status = ST_EMPTY;
        end else if (r.tail) begin
          res.data = deq_slots[slot_at(deq_count - 1)];
          deq_count--;
        end else begin
          res.data = deq_slots[deq_head];
          deq_head = deq_head + 6'd1;
          deq_count--;
        end
      end
      REQ_READ: begin
        // from_tail is ignored; position always counts from the head
        if (r.pos >= deq_count) res.status = ST_RANGE;
        else res.data = deq_slots[slot_at(r.pos)];
      end
      default: begin
        for (k = 0; k < deq_count && hit_at < 0; k++) begin
          idx = r.tail ? (deq_count - 1 - k) : k;
          if (deq_slots[slot_at(idx)] === r.value) hit_at = idx;
        end
        if (hit_at < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.data = deq_slots[slot_at(hit_at)];
          // entries behind the match slide toward the head
          for (k = hit_at; k + 1 < deq_count; k++)
            deq_slots[slot_at(k)] = deq_slots[slot_at(k + 1)];
          deq_count--;
        end
      end
    endcase
    res.count = deq_count;
    kind_hits[r.kind]++;
    status_hits[res.status]++;
    return res;
  endfunction

  task automatic add_req(req_t kind, logic tail, logic signed [31:0] value,
                         logic [5:0] pos, bit drain_first = 1'b0);
    request_t r;
    r.kind        = kind;
    r.tail        = tail;
    r.value       = value;
    r.pos         = pos;
    r.drain_first = drain_first;
    stim_q.push_back(r);
  endtask

  // Mostly words from a small pool so that removes find matches.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Random part: runs of fill, drain, mixed and search-heavy traffic, so the
  // deque swings between empty and full and the head wraps many times.
  task automatic build_random(int n);
    int    made;
    int    mode;
    int    run_len;
    int    roll;
    req_t  kind;
    made = 0;
    while (made < n) begin
      mode    = $urandom_range(0, 3);
      run_len = (mode < 2) ? $urandom_range(80, 130) : $urandom_range(20, 80);
      for (int i = 0; i < run_len && made < n; i++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: kind = (roll < 88) ? REQ_PUSH : req_t'($urandom_range(1, 3));
          1: kind = (roll < 80) ? REQ_POP  : req_t'($urandom_range(0, 3));
          2: kind = req_t'($urandom_range(0, 3));
          default: kind = (roll < 45) ? REQ_REMOVE : (roll < 75) ? REQ_READ : REQ_PUSH;
        endcase
        add_req(kind, 1'($urandom_range(0, 1)), pick_value(),
                ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 15)),
                (made == 0) || (made == 600));
        made++;
      end
    end
  endtask

  // Driver: offers the head of stim_q, holds it while stalled, predicts on
  // acceptance. Each output gets at most one nonblocking assignment per edge.
  always @(posedge clk) begin
    logic     offer;
    request_t nxt;
    offer = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(deque_apply(stim_q.pop_front()));
        items_accepted++;
        offer = 1'b0;
      end
      if (!offer && stim_q.size() > 0) begin
        nxt = stim_q[0];
        if (nxt.drain_first && pending_results.size() != 0) begin
          offer = 1'b0; // pause until the block has handed everything back
        end else if ((items_accepted < CALM_FIRST || items_accepted >= CALM_LAST)
                     && $urandom_range(0, 99) < 30) begin
          offer = 1'b0;
        end else begin
          offer = 1'b1;
          in_req_type  <= nxt.kind;
          in_from_tail <= nxt.tail;
          in_value     <= nxt.value;
          in_position  <= nxt.pos;
        end
      end
    end
    in_valid <= offer;
  end

  // Monitor: checks each result against the oldest prediction and drives
  // out_stall, including one long back-off to fill the block up.
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    result_t want;
    logic    stall_nxt;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: data %h status %0d count %0d",
                   $time, out_read_value, out_status, out_count);
        end else begin
          want = pending_results.pop_front();
          if (out_read_value !== want.data) begin
            mismatches++;
            $display("%0t: read_value expected %h actual %h",
                     $time, want.data, out_read_value);
          end
          if (out_status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_status);
          end
          if (out_count !== want.count) begin
            mismatches++;
            $display("%0t: count expected %0d actual %0d",
                     $time, want.count, out_count);
          end
        end
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
        stall_nxt = 1'b0;
      end else begin
        stall_nxt = ($urandom_range(0, 99) < 30);
      end
      out_stall <= stall_nxt;
    end
  end

  // Watchdog: any handshake resets the quiet counter.
  int quiet = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no handshake for %0d cycles, %0d items still queued",
                 $time, QUIET_MAX, stim_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = 32'shFFFF_FFFF;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // Directed: failures on an empty deque, extreme words at both ends,
    // reads at the edges of the range, duplicate matches from both ends.
    add_req(REQ_POP,    1'b0, 0, 0);
    add_req(REQ_POP,    1'b1, 0, 0);
    add_req(REQ_READ,   1'b0, 0, 0);
    add_req(REQ_REMOVE, 1'b0, 0, 0);
    add_req(REQ_PUSH,   1'b1, 32'sh7FFF_FFFF, 0);
    add_req(REQ_PUSH,   1'b0, 32'sh8000_0000, 0);
    add_req(REQ_PUSH,   1'b1, 32'sh0000_0000, 0);
    add_req(REQ_PUSH,   1'b0, 32'shFFFF_FFFF, 0);
    add_req(REQ_PUSH,   1'b1, 32'sh7FFF_FFFF, 0);
    add_req(REQ_READ,   1'b0, 0, 6'd0);
    add_req(REQ_READ,   1'b1, 0, 6'd4);
    add_req(REQ_READ,   1'b0, 0, 6'd5);
    add_req(REQ_READ,   1'b1, 0, 6'd63);
    add_req(REQ_REMOVE, 1'b1, 32'sh7FFF_FFFF, 0); // tail-most duplicate goes
    add_req(REQ_PUSH,   1'b0, 32'sh7FFF_FFFF, 0);
    add_req(REQ_REMOVE, 1'b0, 32'sh7FFF_FFFF, 0); // head-most duplicate goes
    add_req(REQ_REMOVE, 1'b1, 32'sh1234_5678, 0); // no match
    add_req(REQ_READ,   1'b0, 0, 6'd2);
    add_req(REQ_POP,    1'b1, 0, 0);
    add_req(REQ_POP,    1'b0, 0, 0);
    add_req(REQ_POP,    1'b0, 0, 0);
    add_req(REQ_POP,    1'b1, 0, 0);
    add_req(REQ_POP,    1'b1, 0, 0);
    build_random(1180);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_q.size() == 0 && pending_results.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Ran %0d requests (push %0d, pop %0d, read %0d, remove %0d), %0d results checked",
             items_accepted, kind_hits[REQ_PUSH], kind_hits[REQ_POP],
             kind_hits[REQ_READ], kind_hits[REQ_REMOVE], results_seen);
    $display("Status mix: ok %0d, empty %0d, full %0d, out of range %0d, not found %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
             status_hits[ST_RANGE], status_hits[ST_NOTFOUND]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
